// ===== rtl/lltv_pkg.sv =====
// Shared types and codes for the LLDPDU TLV frame validator.
`default_nettype none

package lltv_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 1024;

  // Result queue depth; input is taken while at least two slots are free.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_DATA_W  = 56;

  // Parse position inside the frame.
  typedef enum logic [1:0] {
    POS_HDR0  = 2'd0,
    POS_HDR1  = 2'd1,
    POS_VALUE = 2'd2,
    POS_IDLE  = 2'd3
  } pos_t;

  // Mandatory TLV sequence progress.
  typedef enum logic [1:0] {
    PH_CHASSIS = 2'd0,
    PH_PORT    = 2'd1,
    PH_TTL     = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // First-error codes of the frame verdict.
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_CUT_HDR  = 3'd1,
    ERR_CUT_VAL  = 3'd2,
    ERR_ORDER    = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_NO_END   = 3'd5,
    ERR_TRAILING = 3'd6,
    ERR_TOO_LONG = 3'd7
  } err_t;

  localparam logic [6:0] TLV_END     = 7'd0;
  localparam logic [6:0] TLV_CHASSIS = 7'd1;
  localparam logic [6:0] TLV_PORT    = 7'd2;
  localparam logic [6:0] TLV_TTL     = 7'd3;
  localparam logic [6:0] TLV_CAPS    = 7'd7;
  localparam logic [6:0] TLV_MGMT    = 7'd8;

  localparam logic [1:0] FMT_HEX  = 2'd0;
  localparam logic [1:0] FMT_TEXT = 2'd1;
  localparam logic [1:0] FMT_MAC  = 2'd2;

  localparam logic [1:0] ADDR_NONE = 2'd0;
  localparam logic [1:0] ADDR_IPV4 = 2'd1;
  localparam logic [1:0] ADDR_IPV6 = 2'd2;
  localparam logic [1:0] ADDR_MAC  = 2'd3;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // One result word.
  typedef struct packed {
    logic       kind;
    logic [6:0] tlv_type;
    logic [8:0] tlv_length;
    logic [9:0] value_offset;
    logic [7:0] id_subtype;
    logic [1:0] id_format;
    logic [7:0] capability_mask;
    logic [1:0] mgmt_addr_kind;
    logic       frame_ok;
    err_t       error_code;
    logic       last;
  } res_t;

  // Results produced by one accepted byte: optional record, optional verdict.
  typedef struct packed {
    logic rec_valid;
    res_t rec;
    logic vrd_valid;
    res_t vrd;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/lltv_core.sv =====
// Per-byte TLV parse state and checks; emits record and verdict words.
`default_nettype none

module lltv_core #(
  parameter int MAX_FRAME_BYTES = lltv_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_fire,
  input  wire logic [7:0]    data_byte,
  input  wire logic          frame_last,
  output lltv_pkg::push_t    push
);
  import lltv_pkg::*;

  localparam int OFS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW    = (OFS_W > 10) ? OFS_W : 10;
  localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_FRAME_BYTES);

  logic [OFS_W-1:0] off_r, off_nxt;
  phase_t           phase_r, phase_nxt;
  pos_t             pos_r, pos_nxt;
  logic [7:0]       hdr0_r, hdr0_nxt;
  logic [6:0]       type_r, type_nxt;
  logic [8:0]       len_r, len_nxt;
  logic [8:0]       vidx_r, vidx_nxt;
  logic [9:0]       vst_r, vst_nxt;
  logic [7:0]       fvb_r, fvb_nxt;
  logic [7:0]       capl_r, capl_nxt;
  logic [7:0]       alen_r, alen_nxt;
  logic [7:0]       asub_r, asub_nxt;
  logic             end_r, end_nxt;
  err_t             err_r, err_nxt;

  function automatic logic [1:0] id_fmt(input logic [6:0] t, input logic [7:0] s,
                                        input logic [8:0] l);
    logic [1:0] f;
    f = FMT_HEX;
    if (t == TLV_CHASSIS) begin
      if (s == 8'd4 && l == 9'd7) f = FMT_MAC;
      else if (s == 8'd1 || s == 8'd2 || s == 8'd3 || s == 8'd6 || s == 8'd7) f = FMT_TEXT;
    end else begin
      if (s == 8'd3 && l == 9'd7) f = FMT_MAC;
      else if (s == 8'd1 || s == 8'd2 || s == 8'd5 || s == 8'd6 || s == 8'd7) f = FMT_TEXT;
    end
    return f;
  endfunction

  function automatic logic [1:0] addr_kind(input logic [7:0] alen, input logic [7:0] asub);
    logic [7:0] a;
    logic [1:0] k;
    a = alen - 8'd1;
    k = ADDR_NONE;
    if (asub == 8'd1 && a == 8'd4) k = ADDR_IPV4;
    else if (asub == 8'd2 && a == 8'd16) k = ADDR_IPV6;
    else if (asub == 8'd6 && a == 8'd6) k = ADDR_MAC;
    return k;
  endfunction

  logic        fail;
  err_t        fail_code;
  logic        done;
  logic [6:0]  h_type;
  logic [8:0]  h_len;
  logic [9:0]  h_vst;
  logic [CW:0] off_p1;
  phase_t      want;
  logic [8:0]  vidx_p1;
  logic [9:0]  oid_pos;
  logic [9:0]  mgmt_total;
  logic [9:0]  min_mgmt;
  logic [7:0]  fvb_eff;
  err_t        vcode;
  res_t        rec;
  res_t        vrd;

  always_comb begin
    off_nxt   = off_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hdr0_nxt  = hdr0_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    vidx_nxt  = vidx_r;
    vst_nxt   = vst_r;
    fvb_nxt   = fvb_r;
    capl_nxt  = capl_r;
    alen_nxt  = alen_r;
    asub_nxt  = asub_r;
    end_nxt   = end_r;
    err_nxt   = err_r;
    fail      = 1'b0;
    fail_code = ERR_OK;
    done      = 1'b0;
    h_type    = hdr0_r[7:1];
    h_len     = {hdr0_r[0], data_byte};
    off_p1    = (CW+1)'(off_r) + (CW+1)'(1);
    h_vst     = off_p1[9:0];
    want      = (h_type == TLV_CHASSIS) ? PH_CHASSIS :
                (h_type == TLV_PORT)    ? PH_PORT    :
                (h_type == TLV_TTL)     ? PH_TTL     : PH_DONE;
    vidx_p1   = vidx_r + 9'd1;
    oid_pos   = {2'b00, alen_r} + 10'd6;
    mgmt_total = {2'b00, alen_r} + 10'd7 + {2'b00, data_byte};
    min_mgmt  = {2'b00, data_byte} + 10'd7;
    fvb_eff   = (vidx_r == 9'd0) ? data_byte : fvb_r;

    if (off_r >= OFS_MAX) begin
      fail      = 1'b1;
      fail_code = ERR_TOO_LONG;
    end else begin
      unique case (pos_r)
        POS_HDR0: begin
          hdr0_nxt = data_byte;
          pos_nxt  = POS_HDR1;
        end
        POS_HDR1: begin
          type_nxt = h_type;
          len_nxt  = h_len;
          vst_nxt  = h_vst;
          vidx_nxt = 9'd0;
          if (phase_r != want) begin
            fail      = 1'b1;
            fail_code = ERR_ORDER;
          end else if ((h_type == TLV_END && h_len != 9'd0) ||
                       ((h_type == TLV_CHASSIS || h_type == TLV_PORT) && h_len < 9'd2) ||
                       (h_type == TLV_TTL && h_len != 9'd2) ||
                       (h_type == TLV_CAPS && h_len != 9'd4) ||
                       (h_type == TLV_MGMT && h_len == 9'd0)) begin
            fail      = 1'b1;
            fail_code = ERR_LENGTH;
          end else if (h_len == 9'd0) begin
            done = 1'b1;
          end else begin
            pos_nxt = POS_VALUE;
          end
        end
        POS_VALUE: begin
          if (vidx_r == 9'd0) fvb_nxt = data_byte;
          if (type_r == TLV_CAPS) begin
            if (vidx_r == 9'd1) capl_nxt = data_byte;
          end else if (type_r == TLV_MGMT) begin
            if (vidx_r == 9'd0) begin
              alen_nxt = data_byte;
              if (data_byte == 8'd0 || {1'b0, len_r} < min_mgmt) begin
                fail      = 1'b1;
                fail_code = ERR_LENGTH;
              end
            end else begin
              if (vidx_r == 9'd1) asub_nxt = data_byte;
              if ({1'b0, vidx_r} == oid_pos && {1'b0, len_r} != mgmt_total) begin
                fail      = 1'b1;
                fail_code = ERR_LENGTH;
              end
            end
          end
          if (!fail) begin
            vidx_nxt = vidx_p1;
            if (vidx_p1 == len_r) done = 1'b1;
          end
        end
        POS_IDLE: begin
          fail      = 1'b1;
          fail_code = ERR_TRAILING;
        end
        default: ;
      endcase
    end

    // Record of a finished TLV; type/len/offset are the header's on a zero-length TLV.
    rec                 = '0;
    rec.kind            = KIND_RECORD;
    rec.tlv_type        = type_nxt;
    rec.tlv_length      = len_nxt;
    rec.value_offset    = vst_nxt;
    if (type_nxt == TLV_CHASSIS || type_nxt == TLV_PORT) begin
      rec.id_subtype = fvb_eff;
      rec.id_format  = id_fmt(type_nxt, fvb_eff, len_nxt);
    end
    if (type_nxt == TLV_CAPS) rec.capability_mask = capl_nxt;
    if (type_nxt == TLV_MGMT) rec.mgmt_addr_kind = addr_kind(alen_nxt, asub_nxt);
    rec.error_code      = ERR_OK;
    rec.last            = !frame_last;

    if (done) begin
      if (type_nxt == TLV_CHASSIS)   phase_nxt = PH_PORT;
      else if (type_nxt == TLV_PORT) phase_nxt = PH_TTL;
      else if (type_nxt == TLV_TTL)  phase_nxt = PH_DONE;
      if (type_nxt == TLV_END) begin
        end_nxt = 1'b1;
        pos_nxt = POS_IDLE;
      end else begin
        pos_nxt = POS_HDR0;
      end
    end
    if (fail) begin
      if (err_r == ERR_OK) err_nxt = fail_code;
      pos_nxt = POS_IDLE;
    end

    if (off_r < OFS_MAX) off_nxt = off_p1[OFS_W-1:0];

    vcode = err_nxt;
    if (vcode == ERR_OK) begin
      unique case (pos_nxt)
        POS_HDR0:  vcode = ERR_NO_END;
        POS_HDR1:  vcode = ERR_CUT_HDR;
        POS_VALUE: vcode = ERR_CUT_VAL;
        default:   vcode = end_nxt ? ERR_OK : ERR_NO_END;
      endcase
    end
    vrd            = '0;
    vrd.kind       = KIND_VERDICT;
    vrd.frame_ok   = (vcode == ERR_OK);
    vrd.error_code = vcode;
    vrd.last       = 1'b1;

    push.rec_valid = byte_fire && done;
    push.rec       = rec;
    push.vrd_valid = byte_fire && frame_last;
    push.vrd       = vrd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_fire && frame_last)) begin
      off_r   <= '0;
      phase_r <= PH_CHASSIS;
      pos_r   <= POS_HDR0;
      hdr0_r  <= '0;
      type_r  <= '0;
      len_r   <= '0;
      vidx_r  <= '0;
      vst_r   <= '0;
      fvb_r   <= '0;
      capl_r  <= '0;
      alen_r  <= '0;
      asub_r  <= '0;
      end_r   <= 1'b0;
      err_r   <= ERR_OK;
    end else if (byte_fire) begin
      off_r   <= off_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hdr0_r  <= hdr0_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      vidx_r  <= vidx_nxt;
      vst_r   <= vst_nxt;
      fvb_r   <= fvb_nxt;
      capl_r  <= capl_nxt;
      alen_r  <= alen_nxt;
      asub_r  <= asub_nxt;
      end_r   <= end_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lltv_outq.sv =====
// Small result queue: takes up to two words per cycle, hands out one.
`default_nettype none

module lltv_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lltv_pkg::push_t push,
  output lltv_pkg::res_t       head,
  output logic                 head_valid,
  input  wire logic            head_ready,
  output logic                 room2
);
  import lltv_pkg::*;

  res_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [1:0]        n_push;
  logic [QPTR_W-1:0] wr_p1;

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_r];
  assign room2      = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop        = head_valid && head_ready;
  assign n_push     = {1'b0, push.rec_valid} + {1'b0, push.vrd_valid};
  assign wr_p1      = wr_r + QPTR_W'(1);

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(n_push);
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.rec_valid) begin
      q_r[wr_r] <= push.rec;
      if (push.vrd_valid) q_r[wr_p1] <= push.vrd;
    end else if (push.vrd_valid) begin
      q_r[wr_r] <= push.vrd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lldp_tlv_frame_validator_unit.sv =====
// Top level of the LLDPDU TLV frame validator.
`default_nettype none

// Usage:
//  - in_*: one LLDPDU byte per word (in_tdata), in_tlast on the frame's final
//    byte. A frame's bytes are streamed back to back; the next frame starts
//    with the word after in_tlast.
//  - out_*: result words. out_tuser = 0 is a TLV record (type, length, value
//    offset, ID subtype/format, capability byte, management address kind),
//    out_tuser = 1 is the frame verdict (pass flag and first-error code).
//    out_tlast marks the last result word caused by one input byte.
//  - Each finished TLV gives a record; the final byte gives a verdict after
//    any record of that same byte, so one byte gives zero, one or two words.
//  - Path: byte parse logic -> 4-entry result queue; results of an accepted byte
//    are written into the queue and show on out_* once older words have left.
//  - Throughput: one byte per cycle. in_tready drops only when fewer than two
//    queue slots are free, i.e. when the receiver stalls on out_tready.
//  - Reset (rst_n low, synchronous) clears parse state and empties the queue;
//    the block is ready for a new frame in the first cycle after reset.
//  - Parse state also returns to its reset value after every frame's last byte.
module lldp_tlv_frame_validator_unit #(
  parameter int MAX_FRAME_BYTES = lltv_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // frame_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [6:0] tlv_type, [15:7] tlv_length, [25:16] value_offset, [33:26] id_subtype,
  // [35:34] id_format, [43:36] capability_mask, [45:44] mgmt_addr_kind,
  // [46] frame_ok, [49:47] error_code, [55:50] zero
  output logic [lltv_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic             out_tuser,  // [0] result_kind
  output logic             out_tlast   // last
);
  import lltv_pkg::*;

  logic  byte_fire;
  logic  room2;
  push_t push;
  res_t  head;

  assign in_tready = room2;
  assign byte_fire = in_tvalid && in_tready;

  lltv_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (byte_fire),
    .data_byte  (in_tdata),
    .frame_last (in_tlast),
    .push       (push)
  );

  lltv_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .head       (head),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .room2      (room2)
  );

  assign out_tdata = {6'b0, head.error_code, head.frame_ok, head.mgmt_addr_kind,
                      head.capability_mask, head.id_format, head.id_subtype,
                      head.value_offset, head.tlv_length, head.tlv_type};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

`default_nettype wire
